// ===== rtl/core/cir_pkg.sv =====
// Shared types and codes for the connection innovation registry.
// Holds the channel beat structs and the controller/datapath link structs.
// No dependencies.
package cir_pkg;

    // Fixed field widths
    localparam int unsigned NODE_W     = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned INNOV_W    = 8;
    localparam int unsigned STATUS_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DST_INPUT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SRC_OUTPUT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    typedef struct packed {
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
    } in_beat_t;

    typedef struct packed {
        logic [INNOV_W-1:0]  innovation;
        logic [STATUS_W-1:0] status;
    } out_beat_t;

    // Controller -> datapath
    typedef struct packed {
        logic                req_load;
        logic                scan_start;
        logic                scan_en;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                append;
        logic                out_load;
    } cir_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic dst_input;
        logic src_output;
        logic hit;
        logic scan_idle;
        logic full;
        logic out_free;
    } cir_sts_t;

endpackage

// ===== rtl/core/connection_innovation_registry_top.sv =====
// Top level of the connection innovation registry.
// Joins cir_ctrl and cir_datapath; depends on cir_pkg.
//
//   channel  direction  beat                      handshake
//   in       input      src_node, dst_node        in_valid / in_stall
//   out      output     innovation, status        out_valid / out_stall
//   cfg      input      input_count, output_count cfg_we (no wait)
//
// A rejected request goes from S_CHECK straight to S_EMIT, which sets out_valid.
// A scanned request goes through S_SCAN, which ends on a hit at index i or, on a miss,
// once all stored pairs are compared; the scan reads one stored pair per cycle
// from the single read port of the pair memory.
// Reset clears control, config and count registers, not data registers or pair memory.
// A new request is taken while a finished result still waits on out_stall.
module connection_innovation_registry_top #(
    parameter int unsigned MAX_ENTRIES = 256,
    parameter int unsigned NODE_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cir_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  cir_pkg::in_beat_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output cir_pkg::out_beat_t             out_data
);

    cir_pkg::cir_cmd_t cmd;
    cir_pkg::cir_sts_t sts;

    cir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    cir_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NODE_BITS   (NODE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Never append into a full table
    a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !sts.full)
        else $error("append issued with table full");

    // A pending output beat is never overwritten
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("output register overwritten while stalled");

    // A found result comes only from a live compare hit
    a_found_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && (cmd.res_status == cir_pkg::ST_FOUND)) |-> sts.hit)
        else $error("found result without a compare hit");

    // A fresh scan starts with an empty compare stage
    a_scan_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> !sts.hit)
        else $error("stale compare hit at scan start");

endmodule

// ===== rtl/core/cir_ctrl.sv =====
// Controller for the connection innovation registry.
// Sequences check, table scan, append and result hand-off; depends on cir_pkg.
module cir_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cir_pkg::cir_sts_t sts,
    output cir_pkg::cir_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = cir_pkg::ST_FOUND;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.dst_input)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = cir_pkg::ST_DST_INPUT;
                    state_next     = S_EMIT;
                end
                else if (sts.src_output)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = cir_pkg::ST_SRC_OUTPUT;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.hit)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = cir_pkg::ST_FOUND;
                    state_next     = S_EMIT;
                end
                else if (sts.scan_idle)
                begin
                    cmd.res_load = 1'b1;
                    if (sts.full)
                    begin
                        cmd.res_status = cir_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.append     = 1'b1;
                        cmd.res_status = cir_pkg::ST_ADDED;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/cir_datapath.sv =====
// Datapath for the connection innovation registry: config registers, request
// registers, pair memory with one read per cycle, compare stage and output register.
// Depends on cir_pkg.
module cir_datapath #(
    parameter int unsigned MAX_ENTRIES = 256,
    parameter int unsigned NODE_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cir_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  cir_pkg::in_beat_t                 in_data,
    input  logic                              out_stall,
    input  cir_pkg::cir_cmd_t                 cmd,
    output cir_pkg::cir_sts_t                 sts,
    output logic                              out_valid,
    output cir_pkg::out_beat_t                out_data
);

    localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMP_W = 33;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    typedef struct packed {
        logic [NODE_BITS-1:0] src;
        logic [NODE_BITS-1:0] dst;
    } pair_t;

    // Configuration
    logic [cir_pkg::CFG_DATA_W-1:0] input_count_reg;
    logic [cir_pkg::CFG_DATA_W-1:0] output_count_reg;

    // Request, reduced to NODE_BITS
    logic [NODE_BITS-1:0] src_n;
    logic [NODE_BITS-1:0] dst_n;
    logic [NODE_BITS-1:0] src_reg;
    logic [NODE_BITS-1:0] dst_reg;

    // Table state and scan
    pair_t            mem [MAX_ENTRIES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] scan_idx_reg;
    logic [CNT_W-1:0] scan_idx_next;
    logic             cmp_valid_reg;
    logic             cmp_valid_next;
    logic [CNT_W-1:0] cmp_idx_reg;
    pair_t            rd_data_reg;
    logic             issue;
    logic             match;

    // Result and output stage
    logic [cir_pkg::INNOV_W-1:0]  res_idx_reg;
    logic [cir_pkg::STATUS_W-1:0] res_status_reg;
    logic [cir_pkg::INNOV_W-1:0]  res_idx_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    cir_pkg::out_beat_t           out_data_reg;

    logic [CMP_W-1:0] first_output;
    logic [CMP_W-1:0] past_outputs;
    logic [CMP_W-1:0] src_w;
    logic [CMP_W-1:0] dst_w;

    // Node id reduction: keep the low NODE_BITS bits, zero above NODE_W
    for (genvar b = 0; b < NODE_BITS; b++)
    begin : g_node
        if (b < cir_pkg::NODE_W)
        begin : g_copy
            assign src_n[b] = in_data.src_node[b];
            assign dst_n[b] = in_data.dst_node[b];
        end
        else
        begin : g_zero
            assign src_n[b] = 1'b0;
            assign dst_n[b] = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg  <= '0;
            output_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cir_pkg::REG_INPUT_COUNT:  input_count_reg  <= cfg_data;
                cir_pkg::REG_OUTPUT_COUNT: output_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            src_reg <= src_n;
            dst_reg <= dst_n;
        end
    end

    // Node class checks
    assign first_output = CMP_W'(input_count_reg) + CMP_W'(1);
    assign past_outputs = first_output + CMP_W'(output_count_reg);
    assign src_w        = CMP_W'(src_reg);
    assign dst_w        = CMP_W'(dst_reg);

    // Scan control: one read issued per cycle, compared in the following cycle
    assign issue = (scan_idx_reg < count_reg);
    assign match = ((rd_data_reg.src == src_reg) && (rd_data_reg.dst == dst_reg))
                || ((rd_data_reg.src == dst_reg) && (rd_data_reg.dst == src_reg));

    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan_en)
        begin
            cmp_valid_next = issue;
            if (issue)
            begin
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
        end
    end

    assign count_next = cmd.append ? (count_reg + CNT_W'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // Pair memory: append write, registered scan read
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{src: src_reg, dst: dst_reg};
        end
        if (cmd.scan_en && issue)
        begin
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
            cmp_idx_reg <= scan_idx_reg;
        end
    end

    // Result index by outcome
    always_comb
    begin
        case (cmd.res_status)
            cir_pkg::ST_FOUND: res_idx_next = cir_pkg::INNOV_W'(cmp_idx_reg);
            cir_pkg::ST_ADDED: res_idx_next = cir_pkg::INNOV_W'(count_reg);
            default:           res_idx_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_idx_reg    <= res_idx_next;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_data_reg.innovation <= res_idx_reg;
            out_data_reg.status     <= res_status_reg;
        end
    end

    // Output valid: set on load, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Status to controller
    assign sts.dst_input  = (dst_w < first_output);
    assign sts.src_output = (src_w >= first_output) && (src_w < past_outputs);
    assign sts.hit        = cmp_valid_reg && match;
    assign sts.scan_idle  = !issue && !cmp_valid_reg;
    assign sts.full       = (count_reg == MAX_CNT);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
